// File: sv/ftlru_pkg.sv
// ftlru_pkg: shared types and constants of the flow table with LRU replacement.
// No dependencies.
package ftlru_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int CAP_W           = 9;
	localparam int ID_W            = 64;
	localparam int SLOT_W          = 8;
	localparam logic [CAP_W-1:0] CAP_RST = 9'd256;

	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [15:0] port;
		logic [7:0]  proto;
	} key_t;

endpackage

// File: sv/ftlru_keymem.sv
// ftlru_keymem: key store with registered read and compare against a probe key.
// Depends on ftlru_pkg.
module ftlru_keymem #(
	parameter int MAX_ENTRIES = ftlru_pkg::MAX_ENTRIES_DEF,
	parameter int IDX_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  ftlru_pkg::key_t   wr_key,
	input  logic [IDX_W-1:0]  rd_addr,
	input  ftlru_pkg::key_t   probe,
	output logic              match_s1
);

	ftlru_pkg::key_t mem [MAX_ENTRIES];
	ftlru_pkg::key_t rd_key_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_key;
		end
		rd_key_s1 <= mem[rd_addr];
	end

	assign match_s1 = (rd_key_s1 == probe);

endmodule

// File: sv/flow_table_lru_top.sv
// flow_table_lru_top: fully associative flow table with LRU eviction.
// Depends on ftlru_pkg and ftlru_keymem.
//
//  channel | signals                              | direction
//  in      | in_valid/in_stall, key fields        | request in
//  out     | out_valid/out_stall, id/slot/flags   | result out
//  cfg     | cfg_we, cfg_wdata (capacity)         | register write
//
// An accepted request scans one stored key per cycle through the key
// memory read port, stopping early on a hit. Then come the states write,
// append, done (insert); lread, unlink, append, done (hit); or lread,
// unlink, write, append, done (evict and insert). No new request is
// taken until the result has been loaded into the output register.
// Reset clears valid bits, oldest/newest pointers, count and id counter at once.
// in_stall is high while a request is in work; a held result in the output
// register does not block the next request until it must be loaded.
module flow_table_lru_top #(
	parameter int MAX_ENTRIES = ftlru_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ftlru_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [63:0]                 addr_hi,
	input  logic [63:0]                 addr_lo,
	input  logic [15:0]                 port,
	input  logic [7:0]                  proto,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ftlru_pkg::ID_W-1:0]  flow_id,
	output logic [ftlru_pkg::SLOT_W-1:0] slot,
	output logic                        hit,
	output logic                        evicted
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > ftlru_pkg::CAP_W) ? CNT_W : ftlru_pkg::CAP_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_LREAD  = 3'd2;
	localparam logic [2:0] ST_UNLINK = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_APPEND = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]                 state_q;
	logic [ftlru_pkg::CAP_W-1:0] cap_q;
	ftlru_pkg::key_t            key_q;
	logic [MAX_ENTRIES-1:0]     valid_q;
	logic [IDX_W-1:0]           oldest_q, newest_q;
	logic [CNT_W-1:0]           used_q;
	logic [ftlru_pkg::ID_W-1:0] next_id_q;
	logic [CNT_W-1:0]           scan_q;
	logic [IDX_W-1:0]           free_q;
	logic                       free_fnd_q;
	logic [IDX_W-1:0]           tgt_q, s_q;
	logic                       hit_q, evicted_q;
	logic [ftlru_pkg::ID_W-1:0] fid_q;

	// scan pipeline
	logic                       cmp_vld_s1, cmp_ev_s1;
	logic [IDX_W-1:0]           cmp_idx_s1;
	logic                       match_s1;

	// link and id memories
	logic [IDX_W-1:0]           older_mem [MAX_ENTRIES];
	logic [IDX_W-1:0]           newer_mem [MAX_ENTRIES];
	logic [ftlru_pkg::ID_W-1:0] id_mem    [MAX_ENTRIES];
	logic [IDX_W-1:0]           older_rd_q, newer_rd_q;
	logic [ftlru_pkg::ID_W-1:0] id_rd_q;

	// output register
	logic                        ovalid_q, ohit_q, oevict_q;
	logic [ftlru_pkg::ID_W-1:0]  ofid_q;
	logic [ftlru_pkg::SLOT_W-1:0] oslot_q;

	logic             in_acc, out_acc, out_load, hit_now, scan_end, need_evict;
	logic [IDX_W-1:0] scan_idx;
	logic [CMP_W-1:0] cap_eff;
	logic             ol_we, nl_we;
	logic [IDX_W-1:0] ol_wa, ol_wd, nl_wa, nl_wd;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	assign out_acc   = ovalid_q && !out_stall;
	// result moves into the output register once it is free or leaving
	assign out_load  = (state_q == ST_DONE) && (!ovalid_q || out_acc);
	assign flow_id   = ofid_q;
	assign slot      = oslot_q;
	assign hit       = ohit_q;
	assign evicted   = oevict_q;

	assign scan_idx = scan_q[IDX_W-1:0];
	assign scan_end = (scan_q == CNT_MAX);
	assign hit_now  = cmp_vld_s1 && cmp_ev_s1 && match_s1;

	// capacity zero acts as one, above the table size saturates
	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_eff == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end
	end
	assign need_evict = (CMP_W'(used_q) >= cap_eff) && (used_q != '0);

	ftlru_keymem #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IDX_W(IDX_W)
	) u_keymem (
		.clk(clk),
		.wr_en(state_q == ST_WRITE),
		.wr_addr(s_q),
		.wr_key(key_q),
		.rd_addr(scan_idx),
		.probe(key_q),
		.match_s1(match_s1)
	);

	// link writes: unlink patches neighbors, append chains onto the newest
	always_comb begin
		ol_we = 1'b0; ol_wa = newer_rd_q; ol_wd = older_rd_q;
		nl_we = 1'b0; nl_wa = older_rd_q; nl_wd = newer_rd_q;
		if (state_q == ST_UNLINK && used_q > CNT_W'(1)) begin
			nl_we = (tgt_q != oldest_q);
			ol_we = (tgt_q != newest_q);
		end else if (state_q == ST_APPEND && used_q != '0) begin
			ol_we = 1'b1; ol_wa = s_q;      ol_wd = newest_q;
			nl_we = 1'b1; nl_wa = newest_q; nl_wd = s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ol_we) begin
			older_mem[ol_wa] <= ol_wd;
		end
		if (nl_we) begin
			newer_mem[nl_wa] <= nl_wd;
		end
		if (state_q == ST_WRITE) begin
			id_mem[s_q] <= next_id_q;
		end
		if (state_q == ST_LREAD) begin
			older_rd_q <= older_mem[tgt_q];
			newer_rd_q <= newer_mem[tgt_q];
			id_rd_q    <= id_mem[tgt_q];
		end
		if (in_acc) begin
			key_q <= '{addr_hi: addr_hi, addr_lo: addr_lo, port: port, proto: proto};
		end
		cmp_idx_s1 <= scan_idx;
		cmp_ev_s1  <= valid_q[scan_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= ftlru_pkg::CAP_RST;
			valid_q    <= '0;
			oldest_q   <= '0;
			newest_q   <= '0;
			used_q     <= '0;
			next_id_q  <= '0;
			scan_q     <= '0;
			free_q     <= '0;
			free_fnd_q <= 1'b0;
			tgt_q      <= '0;
			s_q        <= '0;
			hit_q      <= 1'b0;
			evicted_q  <= 1'b0;
			fid_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			ovalid_q   <= 1'b0;
			ohit_q     <= 1'b0;
			oevict_q   <= 1'b0;
			ofid_q     <= '0;
			oslot_q    <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_acc) begin
				ovalid_q <= 1'b0;
			end
			cmp_vld_s1 <= (state_q == ST_SCAN) && !scan_end && !hit_now;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_q     <= '0;
						free_fnd_q <= 1'b0;
						hit_q      <= 1'b0;
						evicted_q  <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						tgt_q   <= cmp_idx_s1;
						s_q     <= cmp_idx_s1;
						hit_q   <= 1'b1;
						state_q <= ST_LREAD;
					end else if (scan_end) begin
						if (need_evict) begin
							tgt_q   <= oldest_q;
							state_q <= ST_LREAD;
						end else begin
							s_q     <= free_q;
							state_q <= ST_WRITE;
						end
					end else begin
						scan_q <= scan_q + CNT_W'(1);
						if (!valid_q[scan_idx] && !free_fnd_q) begin
							free_q     <= scan_idx;
							free_fnd_q <= 1'b1;
						end
					end
				end
				ST_LREAD: begin
					state_q <= ST_UNLINK;
				end
				ST_UNLINK: begin
					if (used_q > CNT_W'(1)) begin
						if (tgt_q == oldest_q) begin
							oldest_q <= newer_rd_q;
						end
						if (tgt_q == newest_q) begin
							newest_q <= older_rd_q;
						end
						used_q <= used_q - CNT_W'(1);
					end else begin
						used_q <= '0;
					end
					if (hit_q) begin
						fid_q   <= id_rd_q;
						state_q <= ST_APPEND;
					end else begin
						// lowest free slot, the freed victim included
						valid_q[tgt_q] <= 1'b0;
						evicted_q      <= 1'b1;
						s_q     <= (free_fnd_q && free_q < tgt_q) ? free_q : tgt_q;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					valid_q[s_q] <= 1'b1;
					fid_q        <= next_id_q;
					next_id_q    <= next_id_q + ftlru_pkg::ID_W'(1);
					state_q      <= ST_APPEND;
				end
				ST_APPEND: begin
					if (used_q == '0) begin
						oldest_q <= s_q;
					end
					newest_q <= s_q;
					used_q   <= used_q + CNT_W'(1);
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						ofid_q   <= fid_q;
						oslot_q  <= ftlru_pkg::SLOT_W'(s_q);
						ohit_q   <= hit_q;
						oevict_q <= evicted_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_MAX)
		else $error("used count above table size");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(ohit_q && oevict_q))
		else $error("hit result marked as eviction");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN))
		else $error("accepted request did not start a scan");

	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (next_id_q == $past(next_id_q) + ftlru_pkg::ID_W'(1)))
		else $error("id counter did not advance on insert");

endmodule
